>>> rtl/sbh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbh_pkg: shared types, constants and helpers for the string bucket hash
// Holds the sequencer state type, the shared ALU opcode type and the byte
// conditioning function used by the hash fold.
// ----------------------------------------------------------------------------
package sbh_pkg;

  localparam int HashW     = 64;
  localparam int BucketW   = 31;
  localparam int ByteW     = 8;
  localparam int DivCntW   = $clog2(HashW);

  localparam logic [BucketW-1:0] BucketReset = BucketW'(1024);
  localparam logic [ByteW-1:0]   UpperA      = 8'h41;
  localparam logic [ByteW-1:0]   UpperZ      = 8'h5A;
  localparam logic [ByteW-1:0]   CaseOffset  = 8'h20;

  localparam int MulShift = 2;
  localparam int SubShift = 3;
  localparam int XorShift = 4;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_XOR
  } alu_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_MUL,
    ST_SUB,
    ST_XOR,
    ST_DIV,
    ST_DONE
  } sbh_state_t;

  // Lower-case A..Z only, then sign-extend as a signed char.
  function automatic logic [HashW-1:0] cond_byte(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] c;
    c = b;
    if (b >= UpperA && b <= UpperZ) begin
      c = b + CaseOffset;
    end
    return {{(HashW-ByteW){c[ByteW-1]}}, c};
  endfunction

endpackage
`default_nettype wire

>>> rtl/string_bucket_hash.sv
`default_nettype none
// ----------------------------------------------------------------------------
// string_bucket_hash: bucket index of a word fed one byte per request
// Folds bytes into a 64-bit running hash and reduces it modulo the bucket
// count when the last byte of a word arrives.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one request carries one byte of a
//   word plus in_last_byte. A request is taken when in_valid is high and
//   in_stall is low. in_stall is high whenever the sequencer is busy.
//   Each byte is taken in the accept cycle, then runs four fold steps (add
//   byte, times 5, minus hash>>3, xor hash<<4), all on one shared 64-bit ALU.
//   On a last byte a restoring remainder follows on the same ALU, one
//   dividend bit per cycle, and the final state then hands the result to
//   the output register. A zero bucket count skips the division.
//   Output channel (out_valid / out_stall): out_bucket_index holds while
//   stalled. The output register frees the sequencer, so the next word's
//   bytes are taken while a result waits; only a second finished result
//   waits in the final state until the first one is taken.
//   Config: cfg_wr_en writes cfg_bucket_count; write only while idle.
//   A bucket count of zero yields index 0.
//   Reset (rst_n low, synchronous): hash cleared, bucket count 1024, no
//   pending result.
// ----------------------------------------------------------------------------
module string_bucket_hash
  import sbh_pkg::*;
(
  input  wire               clk,
  input  wire               rst_n,
  // input channel
  input  wire               in_valid,
  output logic              in_stall,
  input  wire [ByteW-1:0]   in_char_byte,
  input  wire               in_last_byte,
  // result channel
  output logic              out_valid,
  input  wire               out_stall,
  output logic [BucketW-1:0] out_bucket_index,
  // configuration
  input  wire               cfg_wr_en,
  input  wire [BucketW-1:0] cfg_bucket_count
);

  sbh_state_t state_r, state_nxt;

  logic [HashW-1:0]   hash_r, hash_nxt;        // running hash, also dividend
  logic [BucketW-1:0] rem_r, rem_nxt;          // partial remainder
  logic [DivCntW-1:0] cnt_r, cnt_nxt;          // division bit counter
  logic [ByteW-1:0]   byte_r;
  logic               last_r;
  logic [BucketW-1:0] bucket_count_r;
  logic               out_valid_r, out_valid_nxt;
  logic [BucketW-1:0] out_index_r;

  logic               accept;
  logic               load_out;

  alu_op_t            alu_op;
  logic [HashW-1:0]   alu_a, alu_b, alu_y;
  logic               alu_borrow;
  logic [BucketW:0]   trial;                   // shifted remainder, one bit wider

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign trial    = {rem_r, hash_r[HashW-1]};
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  assign out_valid        = out_valid_r;
  assign out_bucket_index = out_index_r;

  sbh_alu u_alu (
    .op     (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .y      (alu_y),
    .borrow (alu_borrow)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_ADD;
      ST_ADD:  state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_SUB;
      ST_SUB:  state_nxt = ST_XOR;
      ST_XOR: begin
        if (!last_r) begin
          state_nxt = ST_IDLE;
        end else if (bucket_count_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV:  if (cnt_r == '0) state_nxt = ST_DONE;
      ST_DONE: if (load_out) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ALU operand selection and datapath updates
  always_comb begin
    alu_op   = ALU_ADD;
    alu_a    = hash_r;
    alu_b    = '0;
    hash_nxt = hash_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        rem_nxt = '0;
        cnt_nxt = DivCntW'(HashW - 1);
      end
      ST_ADD: begin
        alu_b    = cond_byte(byte_r);
        hash_nxt = alu_y;
      end
      ST_MUL: begin
        alu_b    = hash_r << MulShift;
        hash_nxt = alu_y;
      end
      ST_SUB: begin
        alu_op   = ALU_SUB;
        alu_b    = hash_r >> SubShift;
        hash_nxt = alu_y;
      end
      ST_XOR: begin
        alu_op = ALU_XOR;
        alu_b  = hash_r << XorShift;
        // zero bucket count: skip the division, hash cleared, index 0
        if (last_r && bucket_count_r == '0) begin
          hash_nxt = '0;
        end else begin
          hash_nxt = alu_y;
        end
      end
      ST_DIV: begin
        // restoring step: shift in the next dividend bit, subtract if it fits
        alu_op   = ALU_SUB;
        alu_a    = HashW'(trial);
        alu_b    = HashW'(bucket_count_r);
        hash_nxt = hash_r << 1;  // dividend drains to zero, clearing the hash
        rem_nxt  = alu_borrow ? trial[BucketW-1:0] : alu_y[BucketW-1:0];
        cnt_nxt  = cnt_r - 1'b1;
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      hash_r         <= '0;
      bucket_count_r <= BucketReset;
      out_valid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hash_r      <= hash_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        bucket_count_r <= cfg_bucket_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (accept) begin
      byte_r <= in_char_byte;
      last_r <= in_last_byte;
    end
    if (load_out) begin
      out_index_r <= rem_r;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_accept_starts_fold: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_ADD))
    else $error("accepted byte did not start the fold");

  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && cnt_r == '0) |=> (state_r == ST_DONE))
    else $error("division did not finish after the last bit");

  a_hash_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> (hash_r == '0))
    else $error("running hash not cleared at end of word");

  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && bucket_count_r != '0) |=>
      (out_valid_r && out_index_r < $past(bucket_count_r)))
    else $error("bucket index not below bucket count");

endmodule
`default_nettype wire

>>> rtl/sbh_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbh_alu: shared 64-bit add / subtract / xor unit
// This one unit serves every fold step and every restoring-division step.
// Borrow flags a negative difference for the division compare.
// ----------------------------------------------------------------------------
module sbh_alu
  import sbh_pkg::*;
(
  input  wire alu_op_t          op,
  input  wire logic [HashW-1:0] a,
  input  wire logic [HashW-1:0] b,
  output logic      [HashW-1:0] y,
  output logic                  borrow
);

  logic [HashW:0] diff;

  assign diff = {1'b0, a} - {1'b0, b};

  always_comb begin
    borrow = 1'b0;
    unique case (op)
      ALU_ADD: y = a + b;
      ALU_SUB: begin
        y      = diff[HashW-1:0];
        borrow = diff[HashW];
      end
      ALU_XOR: y = a ^ b;
      default: y = a;
    endcase
  end

endmodule
`default_nettype wire
